>>> rtl/first_fit_free_block_allocator_macros.svh
// Assertion macros shared by the first-fit allocator RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef FIRST_FIT_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while the synchronous reset is low.
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while the synchronous reset is low.
`define FFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

>>> rtl/ffa_pkg.sv
// Shared types and constants of the first-fit allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ffa_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = 7;
    localparam int DATA_W = 32;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // How the current transaction ends.
    typedef enum logic [1:0] {
        FIN_NONE = 2'd0,
        FIN_HIT  = 2'd1,
        FIN_MISS = 2'd2,
        FIN_NOP  = 2'd3
    } t_fin;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] rd_addr;
        logic [IDX_W-1:0] idx;
        t_fin             fin;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic nop;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/ffa_ctrl.sv
// Scan controller of the first-fit allocator: state machine and entry index.
// Depends on ffa_pkg and first_fit_free_block_allocator_macros.svh.
`default_nettype none
`include "first_fit_free_block_allocator_macros.svh"

module ffa_ctrl
    import ffa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd.load    = 1'b0;
        o_cmd.rd_addr = '0;
        o_cmd.idx     = r_idx;
        o_cmd.fin     = FIN_NONE;
        case (r_state)
            S_IDLE: begin
                // Entry zero is read while the request is latched.
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_addr = IDX_W'(r_idx + 1'b1);
                if (i_stat.nop) begin
                    o_cmd.fin = FIN_NOP;
                    n_state   = S_IDLE;
                end else if (i_stat.hit) begin
                    o_cmd.fin = FIN_HIT;
                    n_state   = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    o_cmd.fin = FIN_MISS;
                    n_state   = S_IDLE;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `FFA_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `FFA_ASSERT_NXT(a_finish_goes_idle, i_clk, i_rst_n, o_cmd.fin != FIN_NONE, !o_busy)
    `FFA_ASSERT_NXT(a_scan_steps_by_one, i_clk, i_rst_n,
        o_busy && o_cmd.fin == FIN_NONE, o_busy && r_idx == IDX_W'($past(r_idx) + 1'b1))

endmodule

`default_nettype wire

>>> rtl/ffa_dp.sv
// Datapath of the first-fit allocator: request latch, region table memories,
// valid bits, entry count and result registers. Depends on ffa_pkg and the macros.
`default_nettype none
`include "first_fit_free_block_allocator_macros.svh"

module ffa_dp
    import ffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_op,
    input  wire logic [DATA_W-1:0] i_req_size,
    input  wire logic [DATA_W-1:0] i_release_offset,
    output t_dp_stat               o_stat,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_alloc_offset,
    output logic [CNT_W-1:0]       o_valid_count
);

    logic [DATA_W-1:0] mem_start [TABLE_ENTRIES];
    logic [DATA_W-1:0] mem_len   [TABLE_ENTRIES];

    logic                     r_op;
    logic [DATA_W-1:0]        r_size;
    logic [DATA_W-1:0]        r_where;
    logic [DATA_W-1:0]        r_start_q;
    logic [DATA_W-1:0]        r_len_q;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] n_valid;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic                     r_done;
    t_status                  r_status;
    t_status                  n_status;
    logic [DATA_W-1:0]        r_off;
    logic [DATA_W-1:0]        n_off;

    logic              cur_valid;
    logic              exact;
    logic              wr_en;
    logic [DATA_W-1:0] wr_start;
    logic [DATA_W-1:0] wr_len;

    assign cur_valid = r_valid[i_cmd.idx];
    assign exact     = (r_len_q == r_size);

    always_comb begin
        if (r_op == OP_ALLOC) begin
            o_stat.hit = cur_valid && (r_len_q >= r_size);
        end else begin
            o_stat.hit = !cur_valid;
        end
        o_stat.nop = (r_op == OP_RELEASE) && (r_size == '0);
    end

    // Table update, result and count for the finishing transaction.
    always_comb begin
        n_valid  = r_valid;
        n_cnt    = r_cnt;
        n_status = ST_OK;
        n_off    = '0;
        wr_en    = 1'b0;
        wr_start = r_where;
        wr_len   = r_size;
        case (i_cmd.fin)
            FIN_HIT: begin
                if (r_op == OP_ALLOC) begin
                    n_off = r_start_q;
                    if (exact) begin
                        n_valid[i_cmd.idx] = 1'b0;
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end else begin
                        wr_en    = 1'b1;
                        wr_start = r_start_q + r_size;
                        wr_len   = r_len_q - r_size;
                    end
                end else begin
                    wr_en              = 1'b1;
                    n_valid[i_cmd.idx] = 1'b1;
                    if (r_cnt != COUNT_MAX) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            FIN_MISS: begin
                n_status = (r_op == OP_ALLOC) ? ST_NOFIT : ST_FULL;
            end
            FIN_NOP: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = r_status;
                n_off    = r_off;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_size  <= i_req_size;
            r_where <= i_release_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_q <= mem_start[i_cmd.rd_addr];
        r_len_q   <= mem_len[i_cmd.rd_addr];
        if (wr_en) begin
            mem_start[i_cmd.idx] <= wr_start;
            mem_len[i_cmd.idx]   <= wr_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_done  <= (i_cmd.fin != FIN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_off    <= n_off;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_alloc_offset = r_off;
    assign o_valid_count  = r_cnt;

    `FFA_ASSERT_NXT(a_miss_keeps_count, i_clk, i_rst_n,
        i_cmd.fin == FIN_MISS || i_cmd.fin == FIN_NOP, r_cnt == $past(r_cnt))
    `FFA_ASSERT_NXT(a_release_sets_valid, i_clk, i_rst_n,
        i_cmd.fin == FIN_HIT && r_op == OP_RELEASE, r_valid[$past(i_cmd.idx)])
    `FFA_ASSERT_IMP(a_failed_gives_zero, i_clk, i_rst_n,
        o_done && o_status != ST_OK, o_alloc_offset == '0)

endmodule

`default_nettype wire

>>> rtl/first_fit_free_block_allocator.sv
// Top level of the first-fit free block allocator: controller plus datapath.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low. The block then walks the 64-entry region table one entry per clock,
// in index order, through the single read port of the start and length
// memories. When the first matching entry k (counting from zero) is found,
// the table is updated and the result appears in the next cycle for exactly
// one cycle, marked by o_done; the receiver cannot stall it, so it must take
// the result in that cycle. A hit on entry k ends the scan there; busy then
// falls and a new transaction can be accepted. A scan that finds nothing (no
// fit on allocate, table full on release) takes all 64 entries before busy
// falls. A release of size zero changes nothing and finishes without walking
// the table. The valid bits and the entry count are cleared by reset at once;
// there is no clearing pass. The result strobe of one transaction may coincide
// with the acceptance of the next.
`default_nettype none

module first_fit_free_block_allocator
    import ffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_op,
    input  wire logic [DATA_W-1:0] i_req_size,
    input  wire logic [DATA_W-1:0] i_release_offset,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_alloc_offset,
    output logic [CNT_W-1:0]       o_valid_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller sequences the scan and decides how each transaction ends.
    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the table and produces the registered result.
    ffa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_op             (i_op),
        .i_req_size       (i_req_size),
        .i_release_offset (i_release_offset),
        .o_stat           (dp_stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_alloc_offset   (o_alloc_offset),
        .o_valid_count    (o_valid_count)
    );

endmodule

`default_nettype wire
